// ===== rtl/prcs_pkg.sv =====
// ----------------------------------------------------------------------------
// prcs_pkg: shared types and constants for the running statistics block
// Field widths, the channel record, request codes and unit status.
// ----------------------------------------------------------------------------
package prcs_pkg;

  localparam int CHANNELS   = 64;
  localparam int CH_W       = 6;
  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 16;
  localparam int SUM_W      = 32;
  localparam int SQ_W       = 47;
  localparam int FRAC_W     = 8;
  localparam int TOTALIZERS = 4;
  localparam int TOT_IDX_W  = 2;
  localparam int TOT_CFG_W  = 3;
  localparam int MEAN_W     = 24;
  localparam int VAR_W      = 38;

  // serial multiplier
  localparam int MUL_A_W    = 47;
  localparam int MUL_B_W    = 32;
  localparam int PROD_W     = 64;
  localparam int MUL_CNT_W  = 6;

  // serial divider
  localparam int DIVD_W     = 71;
  localparam int DIVS_W     = 32;
  localparam int QUOT_W     = 38;
  localparam int DIV_CNT_W  = 7;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_RESET = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] min_v;
    logic signed [SAMPLE_W-1:0] max_v;
    logic signed [SUM_W-1:0]    sum_v;
    logic [SQ_W-1:0]            sq_v;
    logic [COUNT_W-1:0]         count_v;
  } rec_t;

  localparam rec_t REC_EMPTY = '{
    min_v:   16'sh7FFF,
    max_v:   16'sh8000,
    sum_v:   '0,
    sq_v:    '0,
    count_v: '0
  };

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== rtl/prcs_mul.sv =====
// ----------------------------------------------------------------------------
// prcs_mul: bit-serial shift-add multiplier
// One multiplier bit per cycle; done pulses once the product is complete.
// ----------------------------------------------------------------------------
module prcs_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [prcs_pkg::MUL_A_W-1:0] a,
  input  logic [prcs_pkg::MUL_B_W-1:0] b,
  output logic [prcs_pkg::PROD_W-1:0]  product,
  output prcs_pkg::unit_stat_t         stat
);

  logic [prcs_pkg::PROD_W-1:0]    acc_r;
  logic [prcs_pkg::PROD_W-1:0]    mcand_r;
  logic [prcs_pkg::MUL_B_W-1:0]   mplier_r;
  logic [prcs_pkg::MUL_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        acc_r    <= '0;
        mcand_r  <= prcs_pkg::PROD_W'(a);
        mplier_r <= b;
        cnt_r    <= prcs_pkg::MUL_CNT_W'(prcs_pkg::MUL_B_W);
        busy_r   <= 1'b1;
      end else if (busy_r) begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
        cnt_r    <= cnt_r - prcs_pkg::MUL_CNT_W'(1);
        if (cnt_r == prcs_pkg::MUL_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/prcs_div.sv =====
// ----------------------------------------------------------------------------
// prcs_div: bit-serial restoring divider
// One quotient bit per cycle; ovf flags a quotient wider than the register.
// ----------------------------------------------------------------------------
module prcs_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [prcs_pkg::DIVD_W-1:0]  dividend,
  input  logic [prcs_pkg::DIVS_W-1:0]  divisor,
  output logic [prcs_pkg::QUOT_W-1:0]  quot,
  output logic                         ovf,
  output prcs_pkg::unit_stat_t         stat
);

  logic [prcs_pkg::DIVD_W-1:0]    dvd_r;
  logic [prcs_pkg::DIVS_W-1:0]    dvs_r;
  logic [prcs_pkg::DIVS_W-1:0]    rem_r;
  logic [prcs_pkg::QUOT_W-1:0]    quo_r;
  logic                           ovf_r;
  logic [prcs_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [prcs_pkg::DIVS_W:0] trial;
  logic [prcs_pkg::DIVS_W:0] diff;
  logic                      ge;

  assign trial = {rem_r, dvd_r[prcs_pkg::DIVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
        quo_r  <= '0;
        ovf_r  <= 1'b0;
        cnt_r  <= prcs_pkg::DIV_CNT_W'(prcs_pkg::DIVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[prcs_pkg::DIVS_W-1:0] : trial[prcs_pkg::DIVS_W-1:0];
        quo_r <= {quo_r[prcs_pkg::QUOT_W-2:0], ge};
        ovf_r <= ovf_r | quo_r[prcs_pkg::QUOT_W-1];
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r - prcs_pkg::DIV_CNT_W'(1);
        if (cnt_r == prcs_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quot      = quo_r;
  assign ovf       = ovf_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/per_channel_running_stats.sv =====
// ----------------------------------------------------------------------------
// per_channel_running_stats: running min/max/mean/variance per channel
// Top level with channel record memory, totalizers and request sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ channel (valid/stall): add sample, query,
//   reset stats or clear all, each addressed to one channel. Every request
//   yields one transfer on the out_ channel describing that channel after
//   the request. Totalizer window is set through the APB-style port.
//   One request at a time: in_stall is high while the sequencer is busy.
//   The serial units do the bulk of the work: two 32-step shift-add
//   multiplies (n*sumsq and sum^2) and two 71-step restoring divides
//   (mean and variance), between the record update and the output load.
//   A new request is taken as soon as the sequencer is idle, even while the
//   previous result still sits in the output register.
//   Reset: per-channel valid bits clear at once, so every channel reads as
//   empty right after reset, no clearing pass; reset-stats and clear-all do
//   the same in S_UPD. Totalizer window resets to first 36, count 4.
//   When the receiver stalls, the result holds and the sequencer waits in
//   its final state until the output register is free.
// ----------------------------------------------------------------------------
module per_channel_running_stats (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_req_type,
  input  logic [prcs_pkg::CH_W-1:0]           in_channel,
  input  logic signed [prcs_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                                in_sample_invalid,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [prcs_pkg::CH_W-1:0]           out_out_channel,
  output logic                                out_is_totalizer,
  output logic [prcs_pkg::COUNT_W-1:0]        out_sample_count,
  output logic signed [prcs_pkg::SAMPLE_W-1:0] out_min_value,
  output logic signed [prcs_pkg::SAMPLE_W-1:0] out_max_value,
  output logic signed [prcs_pkg::MEAN_W-1:0]  out_mean_q8,
  output logic [prcs_pkg::VAR_W-1:0]          out_variance_q8,
  output logic signed [prcs_pkg::SAMPLE_W-1:0] out_totalizer_value,
  output logic                                out_dropped,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam logic REG_TOT_FIRST = 1'b0;
  localparam logic REG_TOT_COUNT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_MA_GO, S_MA_WT, S_MB_GO, S_MB_WT,
    S_DM_GO, S_DM_WT, S_DV_GO, S_DV_WT, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [prcs_pkg::CH_W-1:0]      tot_first_r;
  logic [prcs_pkg::TOT_CFG_W-1:0] tot_cnt_r;

  // request held for the whole sequence
  prcs_pkg::req_t                 req_r;
  logic [prcs_pkg::CH_W-1:0]      ch_r;
  logic signed [prcs_pkg::SAMPLE_W-1:0] smp_r;
  logic                           inv_r;

  // record memory and per-entry valid bits
  prcs_pkg::rec_t                 mem [prcs_pkg::CHANNELS];
  logic [prcs_pkg::CHANNELS-1:0]  vld_r;
  prcs_pkg::rec_t                 rd_r;
  logic                           rdv_r;
  prcs_pkg::rec_t                 rec_r;
  logic                           drop_r;

  logic signed [prcs_pkg::SAMPLE_W-1:0] tot_r [prcs_pkg::TOTALIZERS];

  logic [prcs_pkg::PROD_W-1:0]    prod_a_r;
  logic [prcs_pkg::PROD_W-1:0]    prod_b_r;
  logic [prcs_pkg::DIVS_W-1:0]    den_r;
  logic signed [prcs_pkg::MEAN_W-1:0] mean_r;
  logic [prcs_pkg::VAR_W-1:0]     var_r;

  // output register
  logic                           out_valid_r;
  logic [prcs_pkg::CH_W-1:0]      o_ch_r;
  logic                           o_tot_r;
  logic [prcs_pkg::COUNT_W-1:0]   o_cnt_r;
  logic signed [prcs_pkg::SAMPLE_W-1:0] o_min_r;
  logic signed [prcs_pkg::SAMPLE_W-1:0] o_max_r;
  logic signed [prcs_pkg::MEAN_W-1:0]   o_mean_r;
  logic [prcs_pkg::VAR_W-1:0]     o_var_r;
  logic signed [prcs_pkg::SAMPLE_W-1:0] o_totv_r;
  logic                           o_drop_r;

  logic accept;
  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  // totalizer window
  logic [prcs_pkg::TOT_CFG_W-1:0] tcnt;
  logic [prcs_pkg::CH_W:0]        tot_end;
  logic [prcs_pkg::CH_W-1:0]      tdiff;
  logic [prcs_pkg::TOT_IDX_W-1:0] tidx;
  logic                           is_tot;

  assign tcnt    = (tot_cnt_r > prcs_pkg::TOT_CFG_W'(prcs_pkg::TOTALIZERS))
                   ? prcs_pkg::TOT_CFG_W'(prcs_pkg::TOTALIZERS) : tot_cnt_r;
  assign tot_end = {1'b0, tot_first_r} + (prcs_pkg::CH_W+1)'(tcnt);
  assign is_tot  = (ch_r >= tot_first_r) && ({1'b0, ch_r} < tot_end);
  assign tdiff   = ch_r - tot_first_r;
  assign tidx    = tdiff[prcs_pkg::TOT_IDX_W-1:0];

  // record update
  prcs_pkg::rec_t cur;
  prcs_pkg::rec_t add_rec;
  prcs_pkg::rec_t rec_nxt;
  logic signed [31:0] sq_prod;
  logic add_ok;
  logic full;
  logic upd;
  logic wipe;

  assign cur     = rdv_r ? rd_r : prcs_pkg::REC_EMPTY;
  assign sq_prod = smp_r * smp_r;
  assign add_ok  = (req_r == prcs_pkg::REQ_ADD) && !inv_r && !is_tot;
  assign full    = (cur.count_v == '1);
  assign upd     = add_ok && !full;
  assign wipe    = (req_r == prcs_pkg::REQ_RESET) || (req_r == prcs_pkg::REQ_CLEAR);

  always_comb begin
    add_rec.min_v   = (smp_r < cur.min_v) ? smp_r : cur.min_v;
    add_rec.max_v   = (smp_r > cur.max_v) ? smp_r : cur.max_v;
    add_rec.sum_v   = cur.sum_v + prcs_pkg::SUM_W'(smp_r);
    add_rec.sq_v    = cur.sq_v + prcs_pkg::SQ_W'(sq_prod);
    add_rec.count_v = cur.count_v + prcs_pkg::COUNT_W'(1);
    if (wipe) begin
      rec_nxt = prcs_pkg::REC_EMPTY;
    end else if (upd) begin
      rec_nxt = add_rec;
    end else begin
      rec_nxt = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= mem[in_channel];
    end
    if ((state_r == S_UPD) && upd) begin
      mem[ch_r] <= add_rec;
    end
  end

  // serial units
  logic [prcs_pkg::SUM_W-1:0]    abs_sum;
  logic                          mul_start;
  logic [prcs_pkg::MUL_A_W-1:0]  mul_a;
  logic [prcs_pkg::MUL_B_W-1:0]  mul_b;
  logic [prcs_pkg::PROD_W-1:0]   mul_p;
  prcs_pkg::unit_stat_t          mul_st;
  logic                          div_start;
  logic [prcs_pkg::DIVD_W-1:0]   div_n;
  logic [prcs_pkg::DIVS_W-1:0]   div_d;
  logic [prcs_pkg::QUOT_W-1:0]   div_q;
  logic                          div_o;
  prcs_pkg::unit_stat_t          div_st;
  logic [prcs_pkg::PROD_W-1:0]   num;
  logic                          num_pos;
  logic [prcs_pkg::DIVS_W-1:0]   den_c;

  assign abs_sum   = rec_r.sum_v[prcs_pkg::SUM_W-1] ? (~rec_r.sum_v + prcs_pkg::SUM_W'(1))
                                                    : rec_r.sum_v;
  assign mul_start = (state_r == S_MA_GO) || (state_r == S_MB_GO);
  assign mul_a     = (state_r == S_MA_GO) ? rec_r.sq_v : prcs_pkg::MUL_A_W'(abs_sum);
  assign mul_b     = (state_r == S_MA_GO) ? prcs_pkg::MUL_B_W'(rec_r.count_v) : abs_sum;
  assign num_pos   = prod_a_r > prod_b_r;
  assign num       = prod_a_r - prod_b_r;
  assign den_c     = prcs_pkg::DIVS_W'(rec_r.count_v) *
                     prcs_pkg::DIVS_W'(rec_r.count_v - prcs_pkg::COUNT_W'(1));
  assign div_start = (state_r == S_DM_GO) || (state_r == S_DV_GO);
  assign div_n     = (state_r == S_DM_GO)
                     ? {(prcs_pkg::DIVD_W-prcs_pkg::SUM_W-prcs_pkg::FRAC_W)'(0), abs_sum,
                        prcs_pkg::FRAC_W'(0)}
                     : {num[prcs_pkg::DIVD_W-prcs_pkg::FRAC_W-1:0], prcs_pkg::FRAC_W'(0)};
  assign div_d     = (state_r == S_DM_GO) ? prcs_pkg::DIVS_W'(rec_r.count_v) : den_r;

  prcs_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_p),
    .stat    (mul_st)
  );

  prcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quot     (div_q),
    .ovf      (div_o),
    .stat     (div_st)
  );

  // quotient to saturated mean / variance
  logic                              q_big;
  logic signed [prcs_pkg::MEAN_W-1:0] mean_nxt;
  logic [prcs_pkg::VAR_W-1:0]        var_nxt;

  assign q_big = div_o || (|div_q[prcs_pkg::QUOT_W-1:prcs_pkg::MEAN_W]);

  always_comb begin
    if (rec_r.count_v == '0) begin
      mean_nxt = '0;
    end else if (!rec_r.sum_v[prcs_pkg::SUM_W-1]) begin
      mean_nxt = (q_big || div_q[prcs_pkg::MEAN_W-1]) ? 24'sh7FFFFF
                                                      : div_q[prcs_pkg::MEAN_W-1:0];
    end else if (q_big || (div_q[prcs_pkg::MEAN_W-1] && (|div_q[prcs_pkg::MEAN_W-2:0]))) begin
      mean_nxt = 24'sh800000;
    end else begin
      mean_nxt = ~div_q[prcs_pkg::MEAN_W-1:0] + prcs_pkg::MEAN_W'(1);
    end
    if ((rec_r.count_v < prcs_pkg::COUNT_W'(2)) || !num_pos) begin
      var_nxt = '0;
    end else if (div_o) begin
      var_nxt = '1;
    end else begin
      var_nxt = div_q;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < prcs_pkg::TOTALIZERS; i++) begin
        tot_r[i] <= '0;
      end
    end else begin
      // the final state reloads the output register itself
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r   <= prcs_pkg::req_t'(in_req_type);
            ch_r    <= in_channel;
            smp_r   <= in_sample_value;
            inv_r   <= in_sample_invalid;
            rdv_r   <= vld_r[in_channel];
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          rec_r  <= rec_nxt;
          drop_r <= add_ok && full;
          if (wipe) begin
            vld_r <= '0;
          end else if (upd) begin
            vld_r[ch_r] <= 1'b1;
          end
          if (req_r == prcs_pkg::REQ_CLEAR) begin
            for (int i = 0; i < prcs_pkg::TOTALIZERS; i++) begin
              tot_r[i] <= '0;
            end
          end else if ((req_r == prcs_pkg::REQ_ADD) && !inv_r && is_tot) begin
            tot_r[tidx] <= smp_r;
          end
          state_r <= S_MA_GO;
        end
        S_MA_GO: begin
          den_r   <= den_c;
          state_r <= S_MA_WT;
        end
        S_MA_WT: begin
          if (mul_st.done) begin
            prod_a_r <= mul_p;
            state_r  <= S_MB_GO;
          end
        end
        S_MB_GO: state_r <= S_MB_WT;
        S_MB_WT: begin
          if (mul_st.done) begin
            prod_b_r <= mul_p;
            state_r  <= S_DM_GO;
          end
        end
        S_DM_GO: state_r <= S_DM_WT;
        S_DM_WT: begin
          if (div_st.done) begin
            mean_r  <= mean_nxt;
            state_r <= S_DV_GO;
          end
        end
        S_DV_GO: state_r <= S_DV_WT;
        S_DV_WT: begin
          if (div_st.done) begin
            var_r   <= var_nxt;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            o_ch_r      <= ch_r;
            o_tot_r     <= is_tot;
            o_cnt_r     <= rec_r.count_v;
            o_min_r     <= rec_r.min_v;
            o_max_r     <= rec_r.max_v;
            o_mean_r    <= mean_r;
            o_var_r     <= var_r;
            o_totv_r    <= is_tot ? tot_r[tidx] : '0;
            o_drop_r    <= drop_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_out_channel     = o_ch_r;
  assign out_is_totalizer    = o_tot_r;
  assign out_sample_count    = o_cnt_r;
  assign out_min_value       = o_min_r;
  assign out_max_value       = o_max_r;
  assign out_mean_q8         = o_mean_r;
  assign out_variance_q8     = o_var_r;
  assign out_totalizer_value = o_totv_r;
  assign out_dropped         = o_drop_r;

  // configuration port
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_first_r <= prcs_pkg::CH_W'(36);
      tot_cnt_r   <= prcs_pkg::TOT_CFG_W'(4);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TOT_FIRST: tot_first_r <= pwdata[prcs_pkg::CH_W-1:0];
        REG_TOT_COUNT: tot_cnt_r   <= pwdata[prcs_pkg::TOT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TOT_FIRST: prdata = 32'(tot_first_r);
      REG_TOT_COUNT: prdata = 32'(tot_cnt_r);
      default:       prdata = '0;
    endcase
  end

`ifndef ASSERT_OFF
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result transfer raised outside the final state");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_st.busy && div_st.busy))
    else $error("multiplier and divider busy together");

  a_var_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_var_r == '0) || (o_cnt_r >= prcs_pkg::COUNT_W'(2)))
    else $error("variance reported with fewer than two samples");

  a_mean_needs_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_mean_r == '0) || (o_cnt_r != '0))
    else $error("mean reported on an empty channel");
`endif

endmodule
